@@ sv/pfrb_pkg.sv @@
// Package for the PCM frame ring buffer: operation codes, register indexes,
// fixed field widths and the status struct passed from control to the top level.
// No dependencies.
`timescale 1ns / 1ps

package pfrb_pkg;

    // Fixed widths of the request and response fields.
    localparam int CAP_W      = 11;  // capacity_frames, fill_level, free_space
    localparam int CH_W       = 4;   // channel_count
    localparam int UNDERRUN_W = 32;  // underrun_total
    localparam int OP_W       = 2;
    localparam int NUM_FIELDS = 8;   // sample fields in each request and response, one per channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CAP_W;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

    typedef struct packed {
        logic                  served;
        logic                  do_write;
        logic                  do_read;
        logic [CAP_W-1:0]      fill_level;
        logic [CAP_W-1:0]      free_space;
        logic [UNDERRUN_W-1:0] underrun_total;
        logic [CH_W-1:0]       channels;
    } ctrl_status_t;

endpackage

@@ sv/pfrb_req_if.sv @@
// Request channel of the PCM frame ring buffer: valid/ready plus one frame operation.
// Depends on pfrb_pkg.
`timescale 1ns / 1ps

interface pfrb_req_if
    import pfrb_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               op;
    logic signed [SAMPLE_BITS-1:0] in_sample0;
    logic signed [SAMPLE_BITS-1:0] in_sample1;
    logic signed [SAMPLE_BITS-1:0] in_sample2;
    logic signed [SAMPLE_BITS-1:0] in_sample3;
    logic signed [SAMPLE_BITS-1:0] in_sample4;
    logic signed [SAMPLE_BITS-1:0] in_sample5;
    logic signed [SAMPLE_BITS-1:0] in_sample6;
    logic signed [SAMPLE_BITS-1:0] in_sample7;

    modport source (
        output valid, op, in_sample0, in_sample1, in_sample2, in_sample3,
               in_sample4, in_sample5, in_sample6, in_sample7,
        input  ready
    );

    modport sink (
        input  valid, op, in_sample0, in_sample1, in_sample2, in_sample3,
               in_sample4, in_sample5, in_sample6, in_sample7,
        output ready
    );
endinterface

@@ sv/pfrb_rsp_if.sv @@
// Response channel of the PCM frame ring buffer: valid/ready plus one result.
// Depends on pfrb_pkg.
`timescale 1ns / 1ps

interface pfrb_rsp_if
    import pfrb_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic                          served;
    logic signed [SAMPLE_BITS-1:0] out_sample0;
    logic signed [SAMPLE_BITS-1:0] out_sample1;
    logic signed [SAMPLE_BITS-1:0] out_sample2;
    logic signed [SAMPLE_BITS-1:0] out_sample3;
    logic signed [SAMPLE_BITS-1:0] out_sample4;
    logic signed [SAMPLE_BITS-1:0] out_sample5;
    logic signed [SAMPLE_BITS-1:0] out_sample6;
    logic signed [SAMPLE_BITS-1:0] out_sample7;
    logic [CAP_W-1:0]              fill_level;
    logic [CAP_W-1:0]              free_space;
    logic [UNDERRUN_W-1:0]         underrun_total;

    modport source (
        output valid, served, out_sample0, out_sample1, out_sample2, out_sample3,
               out_sample4, out_sample5, out_sample6, out_sample7,
               fill_level, free_space, underrun_total,
        input  ready
    );

    modport sink (
        input  valid, served, out_sample0, out_sample1, out_sample2, out_sample3,
               out_sample4, out_sample5, out_sample6, out_sample7,
               fill_level, free_space, underrun_total,
        output ready
    );
endinterface

@@ sv/pfrb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module pfrb_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pfrb_ctrl.sv @@
// Control of the PCM frame ring buffer: configuration registers, ring indices,
// fill count and the saturating underrun counter. Depends on pfrb_pkg.
`timescale 1ns / 1ps

module pfrb_ctrl
    import pfrb_pkg::*;
#(
    parameter int DEPTH_FRAMES = 1024,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [OP_W-1:0]                 op,
    input  logic                            cfg_we,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    output ctrl_status_t                    status,
    output logic [$clog2(DEPTH_FRAMES)-1:0] wr_addr,
    output logic [$clog2(DEPTH_FRAMES)-1:0] rd_addr
);

    localparam int AW = $clog2(DEPTH_FRAMES);
    localparam int XW = ((AW > CAP_W) ? AW : CAP_W) + 1;

    logic [CAP_W-1:0]      cap_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [AW-1:0]         wr_idx_reg, wr_idx_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [CAP_W-1:0]      held_reg, held_next;
    logic [UNDERRUN_W-1:0] urun_reg, urun_next;

    logic [CAP_W-1:0] eff_cap;
    logic [CH_W-1:0]  eff_ch;
    logic             buf_ok;
    logic [XW-1:0]    wr_inc, rd_inc;
    logic             served;
    logic             do_write;
    logic             do_read;

    always_comb
    begin
        // Settings beyond what the hardware holds act as the hardware limit.
        if (XW'(cap_reg) > XW'(DEPTH_FRAMES))
            eff_cap = CAP_W'(DEPTH_FRAMES);
        else
            eff_cap = cap_reg;
        if (ch_reg > CH_W'(MAX_CHANNELS))
            eff_ch = CH_W'(MAX_CHANNELS);
        else
            eff_ch = ch_reg;
        buf_ok = (eff_cap != '0) && (eff_ch != '0);
        wr_inc = XW'(wr_idx_reg) + XW'(1);
        rd_inc = XW'(rd_idx_reg) + XW'(1);
    end

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        held_next   = held_reg;
        urun_next   = urun_reg;
        served      = 1'b0;
        do_write    = 1'b0;
        do_read     = 1'b0;
        case (op)
            OP_WRITE:
            begin
                if (buf_ok && (held_reg < eff_cap) && (XW'(wr_idx_reg) < XW'(eff_cap)))
                begin
                    do_write    = 1'b1;
                    served      = 1'b1;
                    wr_idx_next = (wr_inc >= XW'(eff_cap)) ? '0 : wr_inc[AW-1:0];
                    held_next   = held_reg + CAP_W'(1);
                end
            end
            OP_READ:
            begin
                if (buf_ok && (held_reg != '0) && (XW'(rd_idx_reg) < XW'(eff_cap)))
                begin
                    do_read     = 1'b1;
                    served      = 1'b1;
                    rd_idx_next = (rd_inc >= XW'(eff_cap)) ? '0 : rd_inc[AW-1:0];
                    held_next   = held_reg - CAP_W'(1);
                end
                else if (urun_reg != '1)
                begin
                    urun_next = urun_reg + UNDERRUN_W'(1);
                end
            end
            OP_CLEAR:
            begin
                served      = 1'b1;
                wr_idx_next = '0;
                rd_idx_next = '0;
                held_next   = '0;
                urun_next   = '0;
            end
            default:
            begin
                served = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        status.served         = served;
        status.do_write       = do_write;
        status.do_read        = do_read;
        status.fill_level     = held_next;
        status.free_space     = buf_ok ? (eff_cap - held_next) : '0;
        status.underrun_total = urun_next;
        status.channels       = eff_ch;
    end

    assign wr_addr = wr_idx_reg;
    assign rd_addr = rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_W'(1024);
            ch_reg     <= CH_W'(2);
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            held_reg   <= '0;
            urun_reg   <= '0;
        end
        else if (cfg_we)
        begin
            // A write to either register empties the buffer; the counter is kept.
            if ((cfg_index == REG_CAPACITY) || (cfg_index == REG_CHANNELS))
            begin
                wr_idx_reg <= '0;
                rd_idx_reg <= '0;
                held_reg   <= '0;
            end
            if (cfg_index == REG_CAPACITY)
                cap_reg <= cfg_data;
            if (cfg_index == REG_CHANNELS)
                ch_reg <= cfg_data[CH_W-1:0];
        end
        else if (accept)
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            held_reg   <= held_next;
            urun_reg   <= urun_next;
        end
    end

endmodule

@@ sv/pcm_frame_ring_buffer.sv @@
// PCM frame ring buffer, top level. Writes, clears, refused reads and underruns
// are answered from the response register loaded at acceptance; a served read
// passes the registered read of the frame memory, then the response register.
// One request per cycle while the response register is free; a served read
// holds the request side in ST_READ. Reset clears indices, fill count and counter,
// restores capacity 1024 and two channels; the frame memory is not cleared.
`timescale 1ns / 1ps

module pcm_frame_ring_buffer
    import pfrb_pkg::*;
#(
    parameter int DEPTH_FRAMES = 1024,
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pfrb_req_if.sink              req,
    pfrb_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW      = $clog2(DEPTH_FRAMES);
    localparam int FRAME_W = MAX_CHANNELS * SAMPLE_BITS;

    // The sequencer either waits for a request or, in ST_READ, waits for the frame
    // memory to return the frame of a served read.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    ctrl_status_t     status;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [FRAME_W-1:0] wr_frame;
    logic [FRAME_W-1:0] rd_frame;
    logic             accept;
    logic             rsp_free;

    logic [SAMPLE_BITS-1:0] in_s [NUM_FIELDS];

    // Response register. Levels and counter are loaded when the request is
    // accepted; samples are loaded either then (as zero) or once the memory
    // has answered a served read.
    logic                   valid_reg;
    logic                   served_reg;
    logic [SAMPLE_BITS-1:0] sample_reg [NUM_FIELDS];
    logic [CAP_W-1:0]       fill_reg;
    logic [CAP_W-1:0]       free_reg;
    logic [UNDERRUN_W-1:0]  urun_reg;
    logic [CH_W-1:0]        ch_reg;

    // The response register is free when empty or when it is taken this cycle.
    assign rsp_free  = !valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && rsp_free;
    assign accept    = req.valid && req.ready;

    pfrb_ctrl #(
        .DEPTH_FRAMES (DEPTH_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (req.op),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr)
    );

    // Gather the sample fields into one frame-wide memory word. Channels past
    // the configured count are stored too; they are never shown on a read.
    assign in_s[0] = req.in_sample0;
    assign in_s[1] = req.in_sample1;
    assign in_s[2] = req.in_sample2;
    assign in_s[3] = req.in_sample3;
    assign in_s[4] = req.in_sample4;
    assign in_s[5] = req.in_sample5;
    assign in_s[6] = req.in_sample6;
    assign in_s[7] = req.in_sample7;

    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            wr_frame[c*SAMPLE_BITS +: SAMPLE_BITS] = in_s[c];
        end
    end

    // One frame per memory word. A write lands at the accepting edge, so a read
    // accepted later always sees it.
    pfrb_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DEPTH_FRAMES)
    ) u_frames (
        .clk   (clk),
        .we    (accept && status.do_write),
        .waddr (wr_addr),
        .wdata (wr_frame),
        .re    (accept && status.do_read),
        .raddr (rd_addr),
        .rdata (rd_frame)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.do_read)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
                valid_reg <= 1'b1;
            else if (accept)
                valid_reg <= !status.do_read;
            else if (rsp.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            served_reg <= status.served;
            fill_reg   <= status.fill_level;
            free_reg   <= status.free_space;
            urun_reg   <= status.underrun_total;
            ch_reg     <= status.channels;
            for (int c = 0; c < NUM_FIELDS; c++)
            begin
                sample_reg[c] <= '0;
            end
        end
        else if (state_reg == ST_READ)
        begin
            // Unused channels read as zero; stored samples already have the
            // field width, so no further sign extension is needed.
            for (int c = 0; c < NUM_FIELDS; c++)
            begin
                if ((c < MAX_CHANNELS) && (CH_W'(c) < ch_reg))
                    sample_reg[c] <= rd_frame[(c % MAX_CHANNELS)*SAMPLE_BITS +: SAMPLE_BITS];
                else
                    sample_reg[c] <= '0;
            end
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.served         = served_reg;
    assign rsp.out_sample0    = sample_reg[0];
    assign rsp.out_sample1    = sample_reg[1];
    assign rsp.out_sample2    = sample_reg[2];
    assign rsp.out_sample3    = sample_reg[3];
    assign rsp.out_sample4    = sample_reg[4];
    assign rsp.out_sample5    = sample_reg[5];
    assign rsp.out_sample6    = sample_reg[6];
    assign rsp.out_sample7    = sample_reg[7];
    assign rsp.fill_level     = fill_reg;
    assign rsp.free_space     = free_reg;
    assign rsp.underrun_total = urun_reg;

endmodule
